@@ rtl/hhbp_pkg.sv @@
package hhbp_pkg;

  localparam int unsigned DataW     = 8;
  localparam int unsigned ClassW    = 4;
  localparam int unsigned ErrW      = 3;
  localparam int unsigned CountW    = 11;
  localparam int unsigned MaxLenW   = 10;
  localparam int unsigned StateW    = 4;

  localparam logic [DataW-1:0]   ChCr    = 8'h0D;
  localparam logic [DataW-1:0]   ChLf    = 8'h0A;
  localparam logic [DataW-1:0]   ChColon = 8'h3A;
  localparam logic [DataW-1:0]   ChSpace = 8'h20;
  localparam logic [MaxLenW-1:0] MaxLenReset = 10'd255;
  localparam logic [CountW-1:0]  CountLimit  = 11'd1024;

  typedef enum logic [StateW-1:0] {
    ST_START   = 4'd0,
    ST_KEY     = 4'd1,
    ST_COLON   = 4'd2,
    ST_SPACE   = 4'd3,
    ST_VALUE   = 4'd4,
    ST_CR      = 4'd5,
    ST_LF      = 4'd6,
    ST_END_CR  = 4'd7,
    ST_BODY    = 4'd8,
    ST_ERR_KEY = 4'd9,
    ST_ERR_SP  = 4'd10,
    ST_ERR_VLF = 4'd11,
    ST_ERR_LEN = 4'd12,
    ST_ERR_FLF = 4'd13
  } parse_state_e;

  localparam logic [StateW-1:0] StErrBase = 4'd8;

  typedef enum logic [ClassW-1:0] {
    CL_SKIP    = 4'd0,
    CL_KEY     = 4'd1,
    CL_COLON   = 4'd2,
    CL_SPACE   = 4'd3,
    CL_VALUE   = 4'd4,
    CL_VCR     = 4'd5,
    CL_LLF     = 4'd6,
    CL_FCR     = 4'd7,
    CL_FLF     = 4'd8,
    CL_BODY    = 4'd9,
    CL_ERROR   = 4'd10,
    CL_IGNORED = 4'd11
  } byte_class_e;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE    = 3'd0,
    ERR_KEY_BRK = 3'd1,
    ERR_NO_SP   = 3'd2,
    ERR_VAL_LF  = 3'd3,
    ERR_TOO_LNG = 3'd4,
    ERR_FIN_LF  = 3'd5
  } err_code_e;

  typedef struct packed {
    logic [DataW-1:0] data_byte;
    logic             restart;
  } in_item_t;

  typedef struct packed {
    logic [ClassW-1:0] byte_class;
    logic [ErrW-1:0]   error_code;
    logic [CountW-1:0] value_count;
  } out_item_t;

endpackage

@@ rtl/http_header_byte_parser_top.sv @@
// http header byte parser
//
// input channel: in_valid_i / in_stall_o carry one header byte and a restart
// flag per transaction; restart returns the parser to its start state before
// the byte is classified.
// output channel: out_valid_o / out_stall_i carry one result per input byte:
// byte class, error code and the value byte count of the current line.
// config channel: cfg_valid_i / cfg_ready_o write the 10-bit maximum value
// length; cfg_ready_o is always high. write it only while the block is idle.
//
// path: an input byte is held in the input register, classified, and its result
// is held in the result register that drives the output.
// throughput: one byte per cycle while out_stall_i does not hold a result.
// reset: parser goes to its start state, count clears, max length is 255,
// both stages are emptied.
// stall: while out_stall_i holds a result, one more byte can be taken into
// the input register; after that in_stall_o rises until the result drains.
module http_header_byte_parser_top
  import hhbp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [MaxLenW-1:0] cfg_data_i
);

  logic               s1_valid_q;
  in_item_t           s1_item_q;
  logic               out_valid_q;
  out_item_t          out_item_q;
  parse_state_e       state_q;
  parse_state_e       state_d;
  logic [CountW-1:0]  vbytes_q;
  logic [CountW-1:0]  vbytes_d;
  logic [MaxLenW-1:0] max_len_q;
  out_item_t          result;
  logic               out_free;
  logic               adv;
  logic               in_take;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign adv         = s1_valid_q && out_free;
  assign in_stall_o  = s1_valid_q && !out_free;
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  hhbp_classify u_classify (
    .item_i    (s1_item_q),
    .state_i   (state_q),
    .vbytes_i  (vbytes_q),
    .max_len_i (max_len_q),
    .state_o   (state_d),
    .vbytes_o  (vbytes_d),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= ST_START;
      vbytes_q    <= '0;
      max_len_q   <= MaxLenReset;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
        vbytes_q    <= vbytes_d;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        max_len_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= in_item_i;
    end
    if (adv) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ rtl/hhbp_classify.sv @@
module hhbp_classify
  import hhbp_pkg::*;
(
  input  in_item_t           item_i,
  input  parse_state_e       state_i,
  input  logic [CountW-1:0]  vbytes_i,
  input  logic [MaxLenW-1:0] max_len_i,
  output parse_state_e       state_o,
  output logic [CountW-1:0]  vbytes_o,
  output out_item_t          result_o
);

  parse_state_e      cur_st;
  logic [CountW-1:0] cur_vb;
  parse_state_e      nxt_st;
  logic [CountW-1:0] nxt_vb;
  byte_class_e       cls;
  err_code_e         err;
  logic [DataW-1:0]  b;
  logic              is_brk;
  logic [StateW-1:0] err_off;

  assign b      = item_i.data_byte;
  assign is_brk = (b == ChCr) || (b == ChLf);

  always_comb begin
    cur_st  = item_i.restart ? ST_START : state_i;
    cur_vb  = item_i.restart ? '0 : vbytes_i;
    nxt_st  = cur_st;
    nxt_vb  = cur_vb;
    cls     = CL_SKIP;
    err     = ERR_NONE;
    err_off = cur_st - StErrBase;
    case (cur_st)
      ST_START: begin
        if (!is_brk) begin
          nxt_st = ST_KEY;
          nxt_vb = '0;
          cls    = CL_KEY;
        end
      end
      ST_KEY: begin
        if (b == ChColon) begin
          nxt_st = ST_COLON;
          cls    = CL_COLON;
        end else if (is_brk) begin
          nxt_st = ST_ERR_KEY;
          cls    = CL_ERROR;
          err    = ERR_KEY_BRK;
        end else begin
          cls = CL_KEY;
        end
      end
      ST_COLON: begin
        if (b == ChSpace) begin
          nxt_st = ST_SPACE;
          cls    = CL_SPACE;
        end else begin
          nxt_st = ST_ERR_SP;
          cls    = CL_ERROR;
          err    = ERR_NO_SP;
        end
      end
      ST_SPACE: begin
        nxt_st = ST_VALUE;
        nxt_vb = CountW'(1);
        cls    = CL_VALUE;
      end
      ST_VALUE: begin
        if (b == ChCr) begin
          nxt_st = ST_CR;
          cls    = CL_VCR;
        end else if (cur_vb > {1'b0, max_len_i}) begin
          nxt_st = ST_ERR_LEN;
          cls    = CL_ERROR;
          err    = ERR_TOO_LNG;
        end else begin
          nxt_vb = cur_vb + CountW'(1);
          cls    = CL_VALUE;
        end
      end
      ST_CR: begin
        if (b == ChLf) begin
          nxt_st = ST_LF;
          cls    = CL_LLF;
        end else begin
          nxt_st = ST_ERR_VLF;
          cls    = CL_ERROR;
          err    = ERR_VAL_LF;
        end
      end
      ST_LF: begin
        if (b == ChCr) begin
          nxt_st = ST_END_CR;
          cls    = CL_FCR;
        end else begin
          nxt_st = ST_KEY;
          nxt_vb = '0;
          cls    = CL_KEY;
        end
      end
      ST_END_CR: begin
        if (b == ChLf) begin
          nxt_st = ST_BODY;
          cls    = CL_FLF;
        end else begin
          nxt_st = ST_ERR_FLF;
          cls    = CL_ERROR;
          err    = ERR_FIN_LF;
        end
      end
      ST_BODY: begin
        cls = CL_BODY;
      end
      default: begin
        // sticky error, code held in the state
        cls = CL_IGNORED;
        err = err_code_e'(err_off[ErrW-1:0]);
      end
    endcase
  end

  assign state_o              = nxt_st;
  assign vbytes_o             = nxt_vb;
  assign result_o.byte_class  = cls;
  assign result_o.error_code  = err;
  assign result_o.value_count = nxt_vb;

endmodule

@@ rtl/hhbp_checker.sv @@
module hhbp_checker
  import hhbp_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input in_item_t           in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input out_item_t          out_item_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [MaxLenW-1:0] cfg_data_i
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // error byte always carries a code
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.byte_class == CL_ERROR)
      |-> (out_item_o.error_code != ERR_NONE))
    else $error("error class without code");

  // normal classes carry no code
  a_no_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.byte_class != CL_ERROR)
      && (out_item_o.byte_class != CL_IGNORED)
      |-> (out_item_o.error_code == ERR_NONE))
    else $error("code on normal byte");

  // count never passes the widest limit plus one
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.value_count <= CountLimit))
    else $error("value count out of range");

endmodule

bind http_header_byte_parser_top hhbp_checker u_hhbp_checker (.*);
